// ===== rtl/ssi_pkg.sv =====
`default_nettype none
package ssi_pkg;

   localparam int COORD_W    = 16;
   localparam int DIFF_W     = 17;
   localparam int SIDE_W     = 35;
   localparam int QUO_W      = 19;
   localparam int REM_W      = 53;
   localparam int SNAP_W     = 11;
   localparam int TAN_W      = 16;
   localparam int TAN_FRAC   = 14;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;
   localparam int DIST_W     = 35;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SNAP_DISTANCE = 4'd0,
      REG_ANGLE_TANGENT = 4'd1
   } csr_reg_type;

   typedef struct packed {
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
      coord_type bx1;
      coord_type by1;
      coord_type bx2;
      coord_type by2;
   } seg_pair_type;

   // Item state carried along the divider chain.
   typedef struct packed {
      logic                    hit;
      coord_type               x1;
      coord_type               y1;
      coord_type               x2;
      coord_type               y2;
      logic                    neg_x;
      logic                    neg_y;
      logic [SIDE_W-1:0]       den;
      logic [REM_W-1:0]        rem_x;
      logic [REM_W-1:0]        rem_y;
      logic [QUO_W-1:0]        quo_x;
      logic [QUO_W-1:0]        quo_y;
   } div_pay_type;

   typedef struct packed {
      coord_type out_start_x;
      coord_type out_start_y;
      coord_type out_end_x;
      coord_type out_end_y;
      logic      snapped;
      logic      moved_end;
      logic      clipped;
   } result_type;

   function automatic logic signed [DIFF_W-1:0] sub17(input coord_type a, input coord_type b);
      sub17 = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
   endfunction

   function automatic logic [COORD_W-1:0] abs17(input logic signed [DIFF_W-1:0] v);
      logic signed [DIFF_W-1:0] m;
      m = v[DIFF_W-1] ? -v : v;
      abs17 = m[COORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ssi_if.sv =====
`default_nettype none
interface ssi_req_if;
   logic                  valid;
   logic                  ready;
   ssi_pkg::coord_type    a_start_x;
   ssi_pkg::coord_type    a_start_y;
   ssi_pkg::coord_type    a_end_x;
   ssi_pkg::coord_type    a_end_y;
   ssi_pkg::coord_type    b_start_x;
   ssi_pkg::coord_type    b_start_y;
   ssi_pkg::coord_type    b_end_x;
   ssi_pkg::coord_type    b_end_y;
   modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
   modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                 b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface ssi_rsp_if;
   logic                  valid;
   logic                  ready;
   ssi_pkg::coord_type    out_start_x;
   ssi_pkg::coord_type    out_start_y;
   ssi_pkg::coord_type    out_end_x;
   ssi_pkg::coord_type    out_end_y;
   logic                  snapped;
   logic                  moved_end;
   logic                  clipped;
   modport source (output valid, out_start_x, out_start_y, out_end_x, out_end_y,
                   snapped, moved_end, clipped, input ready);
   modport sink (input valid, out_start_x, out_start_y, out_end_x, out_end_y,
                 snapped, moved_end, clipped, output ready);
   modport monitor (input valid, ready, out_start_x, out_start_y, out_end_x,
                    out_end_y, snapped, moved_end, clipped);
endinterface

interface ssi_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ssi_pkg::CSR_ADDR_W-1:0]      addr;
   logic [ssi_pkg::CSR_DATA_W-1:0]      wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/segment_snap_to_intersection_top.sv =====
`default_nettype none
// Channel  | Direction | Contents
// req_bus  | in        | segment A and reference segment B, signed Q12.4
// rsp_bus  | out       | segment A after snapping, snapped, moved_end, clipped
// csr_bus  | in        | register writes: 0 snap_distance, 1 angle_tangent
//
// One item enters per cycle unless rsp_bus.ready held low stalls the pipeline;
// each item passes 3 front stages, one stage per quotient bit in the 19-cell
// divider chain and 4 back stages from acceptance to the result register.
// Every stage has its own valid bit and only stalls when the stage after it
// is full and blocked, so bubbles close up under a held rsp_bus.ready.
// Reset (synchronous, active high) empties the pipeline and loads the
// registers with their defaults; csr_bus is always ready.
module segment_snap_to_intersection_top #(
   parameter int COORD_FRAC_BITS = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ssi_req_if.sink    req_bus,
   ssi_rsp_if.source  rsp_bus,
   ssi_csr_if.sink    csr_bus
);

   // Configuration registers.
   logic [ssi_pkg::SNAP_W-1:0] snap_ff;
   logic [ssi_pkg::TAN_W-1:0]  tan_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_ff <= ssi_pkg::SNAP_W'(20);
         tan_ff  <= ssi_pkg::TAN_W'(9459);
      end else if (csr_bus.valid) begin
         unique case (ssi_pkg::csr_reg_type'(csr_bus.addr))
            ssi_pkg::REG_SNAP_DISTANCE: begin
               snap_ff <= csr_bus.wdata[ssi_pkg::SNAP_W-1:0];
            end
            ssi_pkg::REG_ANGLE_TANGENT: begin
               tan_ff <= csr_bus.wdata[ssi_pkg::TAN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Gather the input item.
   ssi_pkg::seg_pair_type seg;

   always_comb begin
      seg.x1  = req_bus.a_start_x;
      seg.y1  = req_bus.a_start_y;
      seg.x2  = req_bus.a_end_x;
      seg.y2  = req_bus.a_end_y;
      seg.bx1 = req_bus.b_start_x;
      seg.by1 = req_bus.b_start_y;
      seg.bx2 = req_bus.b_end_x;
      seg.by2 = req_bus.b_end_y;
   end

   // Taps between the front, the divider cells and the back.
   localparam int NCELL = ssi_pkg::QUO_W;
   logic                 tap_valid [NCELL+1];
   logic                 tap_ready [NCELL+1];
   ssi_pkg::div_pay_type tap_pay   [NCELL+1];

   ssi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_seg    (seg),
      .out_valid (tap_valid[0]),
      .out_ready (tap_ready[0]),
      .out_pay   (tap_pay[0])
   );

   // The first cell tests the quotient against 2^18; once set, that bit
   // means the intersection lies far outside the coordinate range.
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      ssi_div_cell #(
         .BIT (NCELL - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (tap_valid[i]),
         .in_ready  (tap_ready[i]),
         .in_pay    (tap_pay[i]),
         .out_valid (tap_valid[i+1]),
         .out_ready (tap_ready[i+1]),
         .out_pay   (tap_pay[i+1])
      );
   end

   ssi_pkg::result_type res;

   ssi_back #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .snap_distance (snap_ff),
      .angle_tangent (tan_ff),
      .in_valid      (tap_valid[NCELL]),
      .in_ready      (tap_ready[NCELL]),
      .in_pay        (tap_pay[NCELL]),
      .out_valid     (rsp_bus.valid),
      .out_ready     (rsp_bus.ready),
      .out_res       (res)
   );

   assign rsp_bus.out_start_x = res.out_start_x;
   assign rsp_bus.out_start_y = res.out_start_y;
   assign rsp_bus.out_end_x   = res.out_end_x;
   assign rsp_bus.out_end_y   = res.out_end_y;
   assign rsp_bus.snapped     = res.snapped;
   assign rsp_bus.moved_end   = res.moved_end;
   assign rsp_bus.clipped     = res.clipped;

endmodule
`default_nettype wire

// ===== rtl/ssi_front.sv =====
`default_nettype none
// Side values, numerator partial products and divider setup (three stages).
module ssi_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire ssi_pkg::seg_pair_type  in_seg,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output ssi_pkg::div_pay_type        out_pay
);

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   assign en3 = !v3_ff || out_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready  = en1;
   assign out_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: side values of both A endpoints against line B.
   logic signed [ssi_pkg::DIFF_W-1:0] ex, ey, ux0, uy0, ux1, uy1;
   logic signed [2*ssi_pkg::DIFF_W-1:0] pa0, pb0, pa1, pb1;
   logic signed [ssi_pkg::SIDE_W-1:0] s0_in, s1_in, s0_ff, s1_ff;
   ssi_pkg::seg_pair_type seg_ff;

   always_comb begin
      ex  = ssi_pkg::sub17(in_seg.bx2, in_seg.bx1);
      ey  = ssi_pkg::sub17(in_seg.by2, in_seg.by1);
      ux0 = ssi_pkg::sub17(in_seg.x1, in_seg.bx1);
      uy0 = ssi_pkg::sub17(in_seg.y1, in_seg.by1);
      ux1 = ssi_pkg::sub17(in_seg.x2, in_seg.bx1);
      uy1 = ssi_pkg::sub17(in_seg.y2, in_seg.by1);
      pa0 = ex * uy0;
      pb0 = ey * ux0;
      pa1 = ex * uy1;
      pb1 = ey * ux1;
      s0_in = $signed({pa0[2*ssi_pkg::DIFF_W-1], pa0})
            - $signed({pb0[2*ssi_pkg::DIFF_W-1], pb0});
      s1_in = $signed({pa1[2*ssi_pkg::DIFF_W-1], pa1})
            - $signed({pb1[2*ssi_pkg::DIFF_W-1], pb1});
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s0_ff  <= s0_in;
         s1_ff  <= s1_in;
         seg_ff <= in_seg;
      end
   end

   // Stage 2: same-side test, divisor magnitude, partial products.
   logic hit_in, hit_ff;
   logic signed [ssi_pkg::SIDE_W:0] den_full;
   logic signed [ssi_pkg::SIDE_W:0] den_abs;
   logic signed [ssi_pkg::SIDE_W-1:0] s0_abs;
   logic [ssi_pkg::SIDE_W-1:0] den_in, den_ff;
   logic signed [ssi_pkg::DIFF_W-1:0] dx, dy;
   logic [ssi_pkg::COORD_W-1:0] adx, ady;
   logic [ssi_pkg::COORD_W+17:0] lox_in, loy_in, lox_ff, loy_ff;
   logic [ssi_pkg::COORD_W+16:0] hix_in, hiy_in, hix_ff, hiy_ff;
   logic negx_in, negy_in, negx_ff, negy_ff;
   ssi_pkg::coord_type x1_ff, y1_ff, x2_ff, y2_ff;

   always_comb begin
      den_full = $signed({s0_ff[ssi_pkg::SIDE_W-1], s0_ff})
               - $signed({s1_ff[ssi_pkg::SIDE_W-1], s1_ff});
      // Equal side values mean parallel lines: no intersection is computed.
      hit_in   = ((s0_ff > 0 && s1_ff > 0) || (s0_ff < 0 && s1_ff < 0))
               && (den_full != '0);
      den_abs  = den_full[ssi_pkg::SIDE_W] ? -den_full : den_full;
      den_in   = den_abs[ssi_pkg::SIDE_W-1:0];
      s0_abs   = s0_ff[ssi_pkg::SIDE_W-1] ? -s0_ff : s0_ff;
      dx       = ssi_pkg::sub17(seg_ff.x2, seg_ff.x1);
      dy       = ssi_pkg::sub17(seg_ff.y2, seg_ff.y1);
      adx      = ssi_pkg::abs17(dx);
      ady      = ssi_pkg::abs17(dy);
      lox_in   = adx * s0_abs[17:0];
      loy_in   = ady * s0_abs[17:0];
      hix_in   = adx * s0_abs[ssi_pkg::SIDE_W-1:18];
      hiy_in   = ady * s0_abs[ssi_pkg::SIDE_W-1:18];
      negx_in  = dx[ssi_pkg::DIFF_W-1] ^ s0_ff[ssi_pkg::SIDE_W-1] ^ den_full[ssi_pkg::SIDE_W];
      negy_in  = dy[ssi_pkg::DIFF_W-1] ^ s0_ff[ssi_pkg::SIDE_W-1] ^ den_full[ssi_pkg::SIDE_W];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         hit_ff  <= hit_in;
         den_ff  <= den_in;
         lox_ff  <= lox_in;
         loy_ff  <= loy_in;
         hix_ff  <= hix_in;
         hiy_ff  <= hiy_in;
         negx_ff <= negx_in;
         negy_ff <= negy_in;
         x1_ff   <= seg_ff.x1;
         y1_ff   <= seg_ff.y1;
         x2_ff   <= seg_ff.x2;
         y2_ff   <= seg_ff.y2;
      end
   end

   // Stage 3: numerator magnitudes plus half the divisor for rounding.
   ssi_pkg::div_pay_type pay_in, pay_ff;

   always_comb begin
      pay_in.hit   = hit_ff;
      pay_in.x1    = x1_ff;
      pay_in.y1    = y1_ff;
      pay_in.x2    = x2_ff;
      pay_in.y2    = y2_ff;
      pay_in.neg_x = negx_ff;
      pay_in.neg_y = negy_ff;
      pay_in.den   = den_ff;
      pay_in.rem_x = ssi_pkg::REM_W'(lox_ff) + (ssi_pkg::REM_W'(hix_ff) << 18)
                   + ssi_pkg::REM_W'(den_ff[ssi_pkg::SIDE_W-1:1]);
      pay_in.rem_y = ssi_pkg::REM_W'(loy_ff) + (ssi_pkg::REM_W'(hiy_ff) << 18)
                   + ssi_pkg::REM_W'(den_ff[ssi_pkg::SIDE_W-1:1]);
      pay_in.quo_x = '0;
      pay_in.quo_y = '0;
   end

   always_ff @(posedge clock) begin
      if (en3) pay_ff <= pay_in;
   end

   assign out_pay = pay_ff;

endmodule
`default_nettype wire

// ===== rtl/ssi_div_cell.sv =====
`default_nettype none
// One restoring-division cell: settles quotient bit BIT for both lanes.
module ssi_div_cell #(
   parameter int BIT = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire ssi_pkg::div_pay_type   in_pay,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output ssi_pkg::div_pay_type        out_pay
);

   logic                 v_ff;
   logic                 en;
   logic [ssi_pkg::REM_W-1:0] dsh;
   ssi_pkg::div_pay_type pay_in, pay_ff;

   assign en        = !v_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff;
   assign out_pay   = pay_ff;

   always_comb begin
      pay_in = in_pay;
      dsh    = ssi_pkg::REM_W'(in_pay.den) << BIT;
      if (in_pay.rem_x >= dsh) begin
         pay_in.rem_x      = in_pay.rem_x - dsh;
         pay_in.quo_x[BIT] = 1'b1;
      end
      if (in_pay.rem_y >= dsh) begin
         pay_in.rem_y      = in_pay.rem_y - dsh;
         pay_in.quo_y[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) pay_ff <= pay_in;
   end

endmodule
`default_nettype wire

// ===== rtl/ssi_back.sv =====
`default_nettype none
// Intersection saturation, snap distance and angle tests (four stages).
module ssi_back #(
   parameter int COORD_FRAC_BITS = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [ssi_pkg::SNAP_W-1:0]     snap_distance,
   input  wire logic [ssi_pkg::TAN_W-1:0]      angle_tangent,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire ssi_pkg::div_pay_type           in_pay,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output ssi_pkg::result_type                 out_res
);

   localparam int R_W   = ssi_pkg::SNAP_W + COORD_FRAC_BITS;
   localparam int RR_W  = 2 * R_W;
   localparam int CMP_W = (RR_W > ssi_pkg::DIST_W) ? RR_W : ssi_pkg::DIST_W;
   localparam int SUM_W = 21;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4 = !v4_ff || out_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready  = en1;
   assign out_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   function automatic logic [ssi_pkg::COORD_W:0] lane_sat(
      input ssi_pkg::coord_type          base,
      input logic [ssi_pkg::QUO_W-1:0]   quo,
      input logic                        neg
   );
      logic signed [SUM_W-1:0] qv;
      logic signed [SUM_W-1:0] sum;
      qv  = $signed({{(SUM_W-ssi_pkg::QUO_W+1){1'b0}}, quo[ssi_pkg::QUO_W-2:0]});
      if (neg) qv = -qv;
      sum = $signed({{(SUM_W-ssi_pkg::COORD_W){base[ssi_pkg::COORD_W-1]}}, base}) + qv;
      if (quo[ssi_pkg::QUO_W-1]) begin
         lane_sat = {1'b1, neg ? ssi_pkg::COORD_MIN : ssi_pkg::COORD_MAX};
      end else if (sum > $signed(SUM_W'(ssi_pkg::COORD_MAX))) begin
         lane_sat = {1'b1, ssi_pkg::COORD_MAX};
      end else if (sum < -$signed(SUM_W'(32768))) begin
         lane_sat = {1'b1, ssi_pkg::COORD_MIN};
      end else begin
         lane_sat = {1'b0, sum[ssi_pkg::COORD_W-1:0]};
      end
   endfunction

   // Stage 1: signed quotient, add to the A start, saturate.
   logic [ssi_pkg::COORD_W:0] satx, saty;
   ssi_pkg::coord_type px1_ff, py1_ff, x1a_ff, y1a_ff, x2a_ff, y2a_ff;
   logic clip1_ff, hit1_ff;

   always_comb begin
      satx = lane_sat(in_pay.x1, in_pay.quo_x, in_pay.neg_x);
      saty = lane_sat(in_pay.y1, in_pay.quo_y, in_pay.neg_y);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         px1_ff   <= satx[ssi_pkg::COORD_W-1:0];
         py1_ff   <= saty[ssi_pkg::COORD_W-1:0];
         clip1_ff <= in_pay.hit && (satx[ssi_pkg::COORD_W] || saty[ssi_pkg::COORD_W]);
         hit1_ff  <= in_pay.hit;
         x1a_ff   <= in_pay.x1;
         y1a_ff   <= in_pay.y1;
         x2a_ff   <= in_pay.x2;
         y2a_ff   <= in_pay.y2;
      end
   end

   // Stage 2: squared distances to both endpoints.
   logic [ssi_pkg::COORD_W-1:0] a0x, a0y, a1x, a1y;
   logic [ssi_pkg::DIST_W-1:0] d0_in, d1_in, d0_ff, d1_ff;
   logic [ssi_pkg::COORD_W-1:0] a0x_ff, a0y_ff, a1x_ff, a1y_ff;
   ssi_pkg::coord_type px2_ff, py2_ff, x1b_ff, y1b_ff, x2b_ff, y2b_ff;
   logic clip2_ff, hit2_ff;

   always_comb begin
      a0x   = ssi_pkg::abs17(ssi_pkg::sub17(x1a_ff, px1_ff));
      a0y   = ssi_pkg::abs17(ssi_pkg::sub17(y1a_ff, py1_ff));
      a1x   = ssi_pkg::abs17(ssi_pkg::sub17(x2a_ff, px1_ff));
      a1y   = ssi_pkg::abs17(ssi_pkg::sub17(y2a_ff, py1_ff));
      d0_in = ssi_pkg::DIST_W'(a0x * a0x) + ssi_pkg::DIST_W'(a0y * a0y);
      d1_in = ssi_pkg::DIST_W'(a1x * a1x) + ssi_pkg::DIST_W'(a1y * a1y);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         d0_ff    <= d0_in;
         d1_ff    <= d1_in;
         a0x_ff   <= a0x;
         a0y_ff   <= a0y;
         a1x_ff   <= a1x;
         a1y_ff   <= a1y;
         px2_ff   <= px1_ff;
         py2_ff   <= py1_ff;
         x1b_ff   <= x1a_ff;
         y1b_ff   <= y1a_ff;
         x2b_ff   <= x2a_ff;
         y2b_ff   <= y2a_ff;
         clip2_ff <= clip1_ff;
         hit2_ff  <= hit1_ff;
      end
   end

   // Stage 3: snap radius test and choice of the kept part.
   logic [R_W-1:0]   rad;
   logic [RR_W-1:0]  rr;
   logic             start_sel, near;
   logic [ssi_pkg::DIST_W-1:0] dmin;
   logic [ssi_pkg::COORD_W-1:0] kx_ff, ky_ff;
   logic start_ff, near_ff, clip3_ff, hit3_ff;
   ssi_pkg::coord_type px3_ff, py3_ff, x1c_ff, y1c_ff, x2c_ff, y2c_ff;

   always_comb begin
      rad       = R_W'(snap_distance) << COORD_FRAC_BITS;
      rr        = RR_W'(rad) * RR_W'(rad);
      start_sel = d0_ff < d1_ff;
      dmin      = start_sel ? d0_ff : d1_ff;
      near      = CMP_W'(dmin) < CMP_W'(rr);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         kx_ff    <= start_sel ? a1x_ff : a0x_ff;
         ky_ff    <= start_sel ? a1y_ff : a0y_ff;
         start_ff <= start_sel;
         near_ff  <= near;
         clip3_ff <= clip2_ff;
         hit3_ff  <= hit2_ff;
         px3_ff   <= px2_ff;
         py3_ff   <= py2_ff;
         x1c_ff   <= x1b_ff;
         y1c_ff   <= y1b_ff;
         x2c_ff   <= x2b_ff;
         y2c_ff   <= y2b_ff;
      end
   end

   // Stage 4: tangent cross-products, decision and result register.
   localparam int PR_W = ssi_pkg::COORD_W + ssi_pkg::TAN_W;
   logic [PR_W-1:0] tx, ty, sx, sy;
   logic            aligned, do_snap;
   ssi_pkg::result_type res_in, res_ff;

   always_comb begin
      tx = PR_W'(angle_tangent) * PR_W'(kx_ff);
      ty = PR_W'(angle_tangent) * PR_W'(ky_ff);
      sx = PR_W'(kx_ff) << ssi_pkg::TAN_FRAC;
      sy = PR_W'(ky_ff) << ssi_pkg::TAN_FRAC;
      if (kx_ff == '0 && ky_ff == '0) begin
         aligned = angle_tangent != '0;
      end else begin
         aligned = (sy < tx) || (sx < ty);
      end
      do_snap = hit3_ff && near_ff && aligned;
      res_in.out_start_x = (do_snap && start_ff) ? px3_ff : x1c_ff;
      res_in.out_start_y = (do_snap && start_ff) ? py3_ff : y1c_ff;
      res_in.out_end_x   = (do_snap && !start_ff) ? px3_ff : x2c_ff;
      res_in.out_end_y   = (do_snap && !start_ff) ? py3_ff : y2c_ff;
      res_in.snapped     = do_snap;
      res_in.moved_end   = do_snap && !start_ff;
      res_in.clipped     = clip3_ff;
   end

   always_ff @(posedge clock) begin
      if (en4) res_ff <= res_in;
   end

   assign out_res = res_ff;

endmodule
`default_nettype wire

// ===== rtl/ssi_checker.sv =====
`default_nettype none
module ssi_checker (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire ssi_pkg::coord_type  rsp_start_x,
   input  wire ssi_pkg::coord_type  rsp_end_x,
   input  wire logic                rsp_snapped,
   input  wire logic                rsp_moved_end
);

   // A result may only claim the end point moved when it snapped.
   a_moved_needs_snap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_snapped || !rsp_moved_end))
      else $error("moved_end set without snapped");

   // Reset empties the pipeline: no result right after it.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   // A blocked result stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_start_x) && $stable(rsp_end_x)
         && $stable(rsp_snapped))
      else $error("stalled result changed");

endmodule

bind segment_snap_to_intersection_top ssi_checker u_ssi_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_start_x   (rsp_bus.out_start_x),
   .rsp_end_x     (rsp_bus.out_end_x),
   .rsp_snapped   (rsp_bus.snapped),
   .rsp_moved_end (rsp_bus.moved_end)
);
`default_nettype wire
